/* rtl/lofsn_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lofsn_pkg
// shared types and constants for letter order from sorted names
// ---------------------------------------------------------------------------
package lofsn_pkg;

   localparam int MAX_LEN_DEFAULT  = 64;
   localparam int ALPHABET_DEFAULT = 26;

   localparam logic OP_LETTER = 1'b0;
   localparam logic OP_SOLVE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CONFLICT = 2'd1;
   localparam logic [1:0] STATUS_OVERLONG = 2'd2;

   typedef struct packed {
      logic       op;
      logic [4:0] letter;
      logic       end_of_name;
   } req_type;

   typedef struct packed {
      logic [4:0] out_letter;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic take_letter;
      logic round_start;
      logic round_step;
      logic emit_step;
      logic clear;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       overlong;
      logic       conflict;
      logic       none_ready;
      logic       all_done;
      logic       emit_last;
   } sts_type;

endpackage

/* rtl/lofsn_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lofsn_datapath
// name buffer, edge matrix, layer assignment and emit scan
// ---------------------------------------------------------------------------
module lofsn_datapath #(
   parameter int MAX_LEN  = lofsn_pkg::MAX_LEN_DEFAULT,
   parameter int ALPHABET = lofsn_pkg::ALPHABET_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  lofsn_pkg::req_type  req,
   input  lofsn_pkg::cmd_type  cmd,
   output lofsn_pkg::sts_type  sts,
   output logic [4:0]          emit_letter,
   output logic                emit_hit
);
   localparam int PW = $clog2(MAX_LEN + 1);
   localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int LW = $clog2(ALPHABET + 1);

   logic [4:0]          name_mem [MAX_LEN];
   logic [ALPHABET-1:0] edges_ff [ALPHABET];
   logic [ALPHABET-1:0] edges_in [ALPHABET];
   logic [LW-1:0]       layer_ff [ALPHABET];
   logic [ALPHABET-1:0] remaining_ff, remaining_in, ready_w;
   logic [PW-1:0]       position_ff, position_in, prev_len_ff, prev_len_in;
   logic                diverged_ff, diverged_in, conflict_ff, conflict_in;
   logic                overlong_ff, overlong_in;
   logic [LW-1:0]       round_ff, round_in, scan_layer_ff, scan_layer_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [LW-1:0]       count_ff, count_in;
   logic [4:0]          before_ff;
   logic                in_range, compare, mem_write;
   logic [IW-1:0]       wr_addr, rd_addr;

   assign in_range  = (position_ff < PW'(MAX_LEN));
   assign compare   = in_range && !diverged_ff && (position_ff < prev_len_ff);
   assign mem_write = cmd.take_letter && in_range;
   assign wr_addr   = position_ff[IW-1:0];
   assign rd_addr   = position_in[IW-1:0];

   // previous letter at the next position is fetched ahead of its transfer
   always_ff @(posedge clock) begin
      if (mem_write) begin
         name_mem[wr_addr] <= req.letter;
      end
      if (mem_write && wr_addr == rd_addr) begin
         before_ff <= req.letter;
      end else begin
         before_ff <= name_mem[rd_addr];
      end
   end

   always_comb begin
      for (int v = 0; v < ALPHABET; v++) begin
         ready_w[v] = remaining_ff[v] && ((edges_ff[v] & remaining_ff) == '0);
      end
   end

   always_comb begin
      edges_in     = edges_ff;
      position_in  = position_ff;
      prev_len_in  = prev_len_ff;
      diverged_in  = diverged_ff;
      conflict_in  = conflict_ff;
      overlong_in  = overlong_ff;
      remaining_in = remaining_ff;
      round_in     = round_ff;
      scan_in      = scan_ff;
      scan_layer_in = scan_layer_ff;
      count_in     = count_ff;
      if (cmd.clear) begin
         for (int v = 0; v < ALPHABET; v++) edges_in[v] = '0;
         position_in = '0;
         prev_len_in = '0;
         diverged_in = 1'b0;
         conflict_in = 1'b0;
         overlong_in = 1'b0;
      end else if (cmd.take_letter) begin
         if (!in_range) begin
            overlong_in = 1'b1;
         end else begin
            if (compare && before_ff != req.letter) begin
               diverged_in = 1'b1;
               if ({1'b0, before_ff} < 6'(ALPHABET)
                   && {1'b0, req.letter} < 6'(ALPHABET)) begin
                  edges_in[req.letter[AW-1:0]][before_ff[AW-1:0]] = 1'b1;
               end
            end
            position_in = position_ff + PW'(1);
         end
         if (req.end_of_name) begin
            if (!diverged_in && position_in < prev_len_ff) conflict_in = 1'b1;
            prev_len_in = position_in;
            position_in = '0;
            diverged_in = 1'b0;
         end
      end
      if (cmd.round_start) begin
         remaining_in  = '1;
         round_in      = '0;
         scan_in       = '0;
         scan_layer_in = '0;
         count_in      = '0;
      end else if (cmd.round_step) begin
         remaining_in = remaining_ff & ~ready_w;
         round_in     = round_ff + LW'(1);
      end else if (cmd.emit_step) begin
         if (layer_ff[scan_ff] == scan_layer_ff) count_in = count_ff + LW'(1);
         if (scan_ff == AW'(ALPHABET - 1)) begin
            scan_in       = '0;
            scan_layer_in = scan_layer_ff + LW'(1);
         end else begin
            scan_in = scan_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.round_step) begin
         for (int v = 0; v < ALPHABET; v++) begin
            if (ready_w[v]) layer_ff[v] <= round_ff;
         end
      end
      remaining_ff  <= remaining_in;
      round_ff      <= round_in;
      scan_ff       <= scan_in;
      scan_layer_ff <= scan_layer_in;
      count_ff      <= count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < ALPHABET; v++) edges_ff[v] <= '0;
         position_ff <= '0;
         prev_len_ff <= '0;
         diverged_ff <= 1'b0;
         conflict_ff <= 1'b0;
         overlong_ff <= 1'b0;
      end else begin
         edges_ff    <= edges_in;
         position_ff <= position_in;
         prev_len_ff <= prev_len_in;
         diverged_ff <= diverged_in;
         conflict_ff <= conflict_in;
         overlong_ff <= overlong_in;
      end
   end

   // emit step is valid when the scanned letter sits in the current layer
   assign emit_hit       = (layer_ff[scan_ff] == scan_layer_ff);
   assign emit_letter    = 5'(scan_ff);
   assign sts.overlong   = overlong_ff;
   assign sts.conflict   = conflict_ff;
   assign sts.none_ready = (ready_w == '0);
   assign sts.all_done   = (remaining_ff == '0);
   assign sts.emit_last  = emit_hit && (count_ff == LW'(ALPHABET - 1));
endmodule

/* rtl/lofsn_control.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lofsn_control
// sequencer for letter intake, layering rounds and emit scan
// ---------------------------------------------------------------------------
module lofsn_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_op,
   input  logic               emit_hit,
   input  lofsn_pkg::sts_type sts,
   output lofsn_pkg::cmd_type cmd,
   output logic               busy,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ROUND = 4'b0010,
      S_EMIT  = 4'b0100,
      S_FAIL  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  fail_ff, fail_in;

   always_comb begin
      state_in   = state_ff;
      fail_in    = fail_ff;
      cmd        = '0;
      rsp_strobe = 1'b0;
      rsp_status = lofsn_pkg::STATUS_OK;
      rsp_last   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_op == lofsn_pkg::OP_LETTER) begin
                  cmd.take_letter = 1'b1;
               end else if (sts.overlong) begin
                  fail_in  = lofsn_pkg::STATUS_OVERLONG;
                  state_in = S_FAIL;
               end else if (sts.conflict) begin
                  fail_in  = lofsn_pkg::STATUS_CONFLICT;
                  state_in = S_FAIL;
               end else begin
                  cmd.round_start = 1'b1;
                  state_in        = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            if (sts.all_done) begin
               state_in = S_EMIT;
            end else if (sts.none_ready) begin
               fail_in  = lofsn_pkg::STATUS_CONFLICT;
               state_in = S_FAIL;
            end else begin
               cmd.round_step = 1'b1;
            end
         end
         S_EMIT: begin
            cmd.emit_step = 1'b1;
            rsp_strobe    = emit_hit;
            rsp_last      = sts.emit_last;
            if (sts.emit_last) begin
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FAIL: begin
            rsp_strobe = 1'b1;
            rsp_status = fail_ff;
            rsp_last   = 1'b1;
            cmd.clear  = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fail_ff  <= lofsn_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         fail_ff  <= fail_in;
      end
   end
endmodule

/* rtl/letter_order_from_sorted_names_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// letter_order_from_sorted_names_top
// derives a letter order from a list of sorted names
// ---------------------------------------------------------------------------
// usage: drive req with start while busy is low. a letter transfer gives no
// result; it only feeds the name buffer compare and write.
// a solve transfer raises busy. on an overlong name or an impossible list
// one result (status 2 or 1, last set) is on rsp in the cycle right after
// the transfer. otherwise the block runs layering rounds until every letter
// has a layer; a cycle in the order gives the status 1 result in the cycle
// after the round that finds no ready letter.
// a good order is scanned letter by letter per layer, one result per hit on
// rsp_strobe. the final result carries last, and the intake state and edge
// matrix are cleared; busy drops in the next cycle. results cannot be
// stalled: each is on rsp for exactly one cycle. reset returns to idle with
// an empty edge matrix, no clearing pass is needed.
// ---------------------------------------------------------------------------
module letter_order_from_sorted_names_top #(
   parameter int MAX_LEN  = lofsn_pkg::MAX_LEN_DEFAULT,
   parameter int ALPHABET = lofsn_pkg::ALPHABET_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lofsn_pkg::req_type req,
   output logic               rsp_strobe,
   output lofsn_pkg::rsp_type rsp
);
   lofsn_pkg::cmd_type cmd;
   lofsn_pkg::sts_type sts;
   logic [4:0]         emit_letter;
   logic [1:0]         status_w;
   logic               last_w;
   logic               emit_hit;

   lofsn_datapath #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
      .clock(clock), .reset(reset), .req(req), .cmd(cmd), .sts(sts),
      .emit_letter(emit_letter), .emit_hit(emit_hit)
   );

   lofsn_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .req_op(req.op),
      .emit_hit(emit_hit), .sts(sts), .cmd(cmd), .busy(busy),
      .rsp_strobe(rsp_strobe), .rsp_status(status_w), .rsp_last(last_w)
   );

   assign rsp.out_letter = (status_w == lofsn_pkg::STATUS_OK) ? emit_letter : 5'd0;
   assign rsp.status     = status_w;
   assign rsp.last       = last_w;

   a_last_clears_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.last |=> !busy) else $error("busy after last");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while idle");
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.status != lofsn_pkg::STATUS_OK |-> rsp.last)
      else $error("failure without last");
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// letter_order_from_sorted_names_top: directed and random name lists are
// sent through the command port, each solve is predicted in the bench and
// every strobed result is compared field by field in arrival order
// ---------------------------------------------------------------------------
module testbench;

   localparam int MAX_NAME  = 64;
   localparam int LETTERS   = 26;
   localparam int CYCLE_CAP = 400000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   lofsn_pkg::req_type req;
   logic               rsp_strobe;
   lofsn_pkg::rsp_type rsp;

   letter_order_from_sorted_names_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_strobe(rsp_strobe), .rsp(rsp)
   );

   // bench copy of the block state
   logic [25:0] edges [LETTERS];
   logic [4:0]  prev_name [MAX_NAME];
   int          prev_len;
   int          name_pos;
   bit          diverged;
   bit          contra;
   bit          overlong;

   lofsn_pkg::rsp_type expected_order [$];
   int      errors;
   int      items_sent;
   int      solves_ok, solves_conflict, solves_overlong;
   int      cycles;
   int      burst_left;
   bit      idle_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic clear_state();
      for (int i = 0; i < LETTERS; i++) edges[i] = '0;
      prev_len = 0;
      name_pos = 0;
      diverged = 0;
      contra   = 0;
      overlong = 0;
   endtask

   task automatic note_letter(logic [4:0] ltr, logic fin);
      if (name_pos >= MAX_NAME) begin
         overlong = 1;
      end else begin
         if (!diverged && name_pos < prev_len && prev_name[name_pos] != ltr) begin
            diverged = 1;
            if (prev_name[name_pos] < LETTERS && ltr < LETTERS)
               edges[ltr][prev_name[name_pos]] = 1'b1;
         end
         prev_name[name_pos] = ltr;
         name_pos++;
      end
      if (fin) begin
         if (!diverged && name_pos < prev_len) contra = 1;
         prev_len = name_pos;
         name_pos = 0;
         diverged = 0;
      end
   endtask

   task automatic solve_order();
      logic [25:0]        remaining;
      logic [25:0]        ready;
      int                 layer [LETTERS];
      int                 rounds;
      int                 k;
      lofsn_pkg::rsp_type r;
      remaining = '1;
      rounds = 0;
      k = 0;
      if (overlong || contra) begin
         r.out_letter = '0;
         r.status = overlong ? lofsn_pkg::STATUS_OVERLONG : lofsn_pkg::STATUS_CONFLICT;
         r.last = 1'b1;
         expected_order.insert(expected_order.size(), r);
         if (overlong) solves_overlong++; else solves_conflict++;
         clear_state();
         return;
      end
      while (remaining != 0) begin
         ready = '0;
         for (int v = 0; v < LETTERS; v++)
            if (remaining[v] && (edges[v] & remaining) == 0) ready[v] = 1'b1;
         if (ready == 0) begin
            r.out_letter = '0;
            r.status = lofsn_pkg::STATUS_CONFLICT;
            r.last = 1'b1;
            expected_order.insert(expected_order.size(), r);
            solves_conflict++;
            clear_state();
            return;
         end
         for (int v = 0; v < LETTERS; v++) if (ready[v]) layer[v] = rounds;
         remaining &= ~ready;
         rounds++;
      end
      for (int rd = 0; rd < rounds; rd++)
         for (int v = 0; v < LETTERS; v++)
            if (layer[v] == rd) begin
               r.out_letter = v[4:0];
               r.status = lofsn_pkg::STATUS_OK;
               r.last = (k == LETTERS - 1);
               expected_order.insert(expected_order.size(), r);
               k++;
            end
      solves_ok++;
      clear_state();
   endtask

   // one transfer, with random gaps between bursts
   task automatic send_item(lofsn_pkg::req_type it);
      if (idle_on && burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      start <= 1'b1;
      req <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      burst_left--;
      items_sent++;
      if (it.op == lofsn_pkg::OP_LETTER) note_letter(it.letter, it.end_of_name);
      else solve_order();
   endtask

   task automatic send_letter(logic [4:0] ltr, logic fin);
      lofsn_pkg::req_type it;
      it.op = lofsn_pkg::OP_LETTER;
      it.letter = ltr;
      it.end_of_name = fin;
      send_item(it);
   endtask

   task automatic send_solve();
      lofsn_pkg::req_type it;
      it.op = lofsn_pkg::OP_SOLVE;
      it.letter = 5'($urandom);
      it.end_of_name = 1'($urandom);
      send_item(it);
   endtask

   task automatic send_name(logic [4:0] word [$]);
      for (int i = 0; i < word.size(); i++) send_letter(word[i], i == word.size() - 1);
   endtask

   always @(posedge clock) begin
      lofsn_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_order.size() == 0) begin
            $error("unexpected result letter %0d status %0d", rsp.out_letter, rsp.status);
            errors++;
         end else begin
            want = expected_order.pop_front();
            if (rsp.out_letter !== want.out_letter) begin
               $error("out_letter expected %0d got %0d", want.out_letter, rsp.out_letter);
               errors++;
            end
            if (rsp.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp.status);
               errors++;
            end
            if (rsp.last !== want.last) begin
               $error("last expected %0d got %0d", want.last, rsp.last);
               errors++;
            end
         end
      end
   end

   task automatic test_empty_and_edges();
      logic [4:0] w [$];
      send_solve();
      w = '{5'd25}; send_name(w);
      w = '{5'd0}; send_name(w);
      w = '{5'd0, 5'd1}; send_name(w);
      w = '{5'd0, 5'd2}; send_name(w);
      send_solve();
   endtask

   task automatic test_prefix_conflict();
      logic [4:0] w [$];
      w = '{5'd1, 5'd2}; send_name(w);
      w = '{5'd1}; send_name(w);
      send_solve();
   endtask

   task automatic test_cycle();
      logic [4:0] w [$];
      w = '{5'd0}; send_name(w);
      w = '{5'd1}; send_name(w);
      w = '{5'd0}; send_name(w);
      send_solve();
   endtask

   task automatic test_out_of_range();
      logic [4:0] w [$];
      w = '{5'd25, 5'd3}; send_name(w);
      w = '{5'd31, 5'd2}; send_name(w);
      w = '{5'd26}; send_name(w);
      send_letter(5'd4, 1'b0);
      send_solve();
   endtask

   task automatic test_overlong();
      logic [4:0] w [$];
      for (int i = 0; i < MAX_NAME + 3; i++) w.insert(w.size(), 5'($urandom_range(0, 31)));
      send_name(w);
      w = '{5'd1, 5'd1}; send_name(w);
      w = '{5'd1}; send_name(w);
      send_solve();
      w.delete();
      for (int i = 0; i < MAX_NAME; i++) w.insert(w.size(), 5'd7);
      send_name(w);
      send_solve();
   endtask

   task automatic send_sorted_list(int names);
      int         rank [LETTERS];
      int         inv [LETTERS];
      int         j, t, k, rk;
      logic [4:0] prev [$];
      logic [4:0] word [$];
      for (int i = 0; i < LETTERS; i++) inv[i] = i;
      for (int i = LETTERS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = inv[i]; inv[i] = inv[j]; inv[j] = t;
      end
      for (int i = 0; i < LETTERS; i++) rank[inv[i]] = i;
      for (int n = 0; n < names; n++) begin
         word.delete();
         if (n == 0) begin
            repeat ($urandom_range(1, 5))
               word.insert(word.size(), 5'(inv[$urandom_range(0, 25)]));
         end else begin
            k = $urandom_range(0, prev.size());
            if (k < prev.size() && rank[prev[k]] == LETTERS - 1) k = prev.size();
            for (int i = 0; i < k; i++) word.insert(word.size(), prev[i]);
            if (k < prev.size()) begin
               rk = $urandom_range(rank[prev[k]] + 1, LETTERS - 1);
               word.insert(word.size(), 5'(inv[rk]));
            end
            while (word.size() < 8 && $urandom_range(0, 2) == 0)
               word.insert(word.size(), 5'(inv[$urandom_range(0, 25)]));
            if (word.size() == 0) word.insert(word.size(), 5'(inv[0]));
         end
         send_name(word);
         prev = word;
      end
   endtask

   task automatic send_noise_list();
      logic [4:0] word [$];
      repeat ($urandom_range(1, 5)) begin
         word.delete();
         repeat ($urandom_range(1, 4)) word.insert(word.size(), 5'($urandom_range(0, 31)));
         send_name(word);
      end
      if ($urandom_range(0, 3) == 0) send_letter(5'($urandom), 1'b0);
   endtask

   task automatic test_random();
      logic [4:0] word [$];
      int         pick;
      while (items_sent < 460) begin
         idle_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 19);
         if (pick < 13) begin
            send_sorted_list($urandom_range(2, 10));
         end else if (pick < 18) begin
            send_noise_list();
         end else if (pick < 19) begin
            send_sorted_list(3);
            send_noise_list();
         end else begin
            word.delete();
            repeat ($urandom_range(MAX_NAME - 1, MAX_NAME + 2))
               word.insert(word.size(), 5'($urandom_range(0, 25)));
            send_name(word);
         end
         send_solve();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      errors = 0;
      items_sent = 0;
      solves_ok = 0;
      solves_conflict = 0;
      solves_overlong = 0;
      cycles = 0;
      burst_left = 3;
      idle_on = 1;
      clear_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_edges();
      test_prefix_conflict();
      test_cycle();
      test_out_of_range();
      test_overlong();
      test_random();
      start <= 1'b0;
      while (expected_order.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d transfers; solves: %0d ordered, %0d impossible, %0d overlong",
               items_sent, solves_ok, solves_conflict, solves_overlong);
      if (errors == 0 && expected_order.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
